// ----- src/ddwcm_pkg.sv -----
// Shared types and constants for the differential-drive wheel command mixer.
// Depends on nothing; every other file in src imports it.
`timescale 1ns / 1ps

package ddwcm_pkg;

    // Configuration port
    localparam int CFG_W     = 24;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_LIN_GAIN  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_YAW_GAIN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_RPM   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PWM_LIMIT = 2'd3;

    localparam int GAIN_W  = 24;
    localparam int RPMLIM_W = 15;
    localparam int PWM_W   = 13;

    localparam logic [GAIN_W-1:0]   LIN_GAIN_RST  = 24'd838861;
    localparam logic [GAIN_W-1:0]   YAW_GAIN_RST  = 24'd4392;
    localparam logic [RPMLIM_W-1:0] MAX_RPM_RST   = 15'd4000;
    localparam logic [PWM_W-1:0]    PWM_LIMIT_RST = 13'd800;

    // Payload widths
    localparam int LIN_W   = 16;
    localparam int TURN_W  = 24;
    localparam int RPM_W   = 16;
    localparam int MOTOR_W = 3;

    // Q24 fixed point
    localparam int Q_SHIFT = 24;

    // Motors per side and the command counter
    localparam int SIDE_MOTORS = 3;
    localparam int IDX_W       = 3;

    localparam logic [MOTOR_W-1:0] LEFT_IDS  [SIDE_MOTORS] = '{3'd1, 3'd5, 3'd2};
    localparam logic [MOTOR_W-1:0] RIGHT_IDS [SIDE_MOTORS] = '{3'd4, 3'd6, 3'd3};

    typedef struct packed {
        logic [GAIN_W-1:0]   lin_gain;
        logic [GAIN_W-1:0]   yaw_gain;
        logic [RPMLIM_W-1:0] max_rpm;
    } kin_cfg_t;

    typedef struct packed {
        logic signed [RPM_W-1:0] left;
        logic signed [RPM_W-1:0] right;
    } pair_t;

endpackage

// ----- src/ddwcm_kin.sv -----
// Kinematics pipeline: input register, products, sums, round and clamp.
// Depends on ddwcm_pkg.
`timescale 1ns / 1ps

module ddwcm_kin (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  ddwcm_pkg::kin_cfg_t                    cfg,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic signed [ddwcm_pkg::LIN_W-1:0]     in_linear_speed,
    input  logic signed [ddwcm_pkg::TURN_W-1:0]    in_turn_rate,
    output logic                                   pair_valid,
    input  logic                                   pair_ready,
    output ddwcm_pkg::pair_t                       pair
);
    import ddwcm_pkg::*;

    localparam int LQ_W  = LIN_W + GAIN_W + 1;   // 41
    localparam int YQ_W  = TURN_W + GAIN_W + 1;  // 49
    localparam int SUM_W = YQ_W + 1;             // 50
    localparam logic [SUM_W-1:0] Q_HALF = SUM_W'(1) << (Q_SHIFT - 1);
    localparam int R_W   = SUM_W - Q_SHIFT;

    // Round half away from zero, then clamp to +/- max
    function automatic logic signed [RPM_W-1:0] round_clamp(
        input logic signed [SUM_W-1:0] q,
        input logic [RPMLIM_W-1:0]     lim
    );
        logic                neg;
        logic [SUM_W-1:0]    mag_plus;
        logic [R_W-1:0]      r;
        logic [RPMLIM_W-1:0] r_sat;
        logic [RPM_W-1:0]    r_ext;
        neg      = q[SUM_W-1];
        // -q + half == ~q + half + 1
        mag_plus = (neg ? ~q : q) + (neg ? Q_HALF + SUM_W'(1) : Q_HALF);
        r        = mag_plus[SUM_W-1:Q_SHIFT];
        r_sat    = (r > R_W'(lim)) ? lim : r[RPMLIM_W-1:0];
        r_ext    = {1'b0, r_sat};
        return neg ? -r_ext : r_ext;
    endfunction

    logic                     a_vld_reg, a_vld_next;
    logic                     b_vld_reg, b_vld_next;
    logic                     c_vld_reg, c_vld_next;
    logic                     d_vld_reg, d_vld_next;
    logic                     a_rdy, b_rdy, c_rdy, d_rdy;

    logic signed [LIN_W-1:0]  lin_reg;
    logic signed [TURN_W-1:0] turn_reg;
    logic signed [LQ_W-1:0]   lin_q_reg;
    logic signed [YQ_W-1:0]   yaw_q_reg;
    logic signed [SUM_W-1:0]  left_q_reg, right_q_reg;
    pair_t                    pair_reg;

    assign d_rdy = !d_vld_reg || pair_ready;
    assign c_rdy = !c_vld_reg || d_rdy;
    assign b_rdy = !b_vld_reg || c_rdy;
    assign a_rdy = !a_vld_reg || b_rdy;

    always_comb begin
        a_vld_next = a_rdy ? in_valid  : a_vld_reg;
        b_vld_next = b_rdy ? a_vld_reg : b_vld_reg;
        c_vld_next = c_rdy ? b_vld_reg : c_vld_reg;
        d_vld_next = d_rdy ? c_vld_reg : d_vld_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            c_vld_reg <= 1'b0;
            d_vld_reg <= 1'b0;
        end else begin
            a_vld_reg <= a_vld_next;
            b_vld_reg <= b_vld_next;
            c_vld_reg <= c_vld_next;
            d_vld_reg <= d_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (a_rdy) begin
            lin_reg  <= in_linear_speed;
            turn_reg <= in_turn_rate;
        end
        if (b_rdy) begin
            lin_q_reg <= LQ_W'(lin_reg * $signed({1'b0, cfg.lin_gain}));
            yaw_q_reg <= YQ_W'(turn_reg * $signed({1'b0, cfg.yaw_gain}));
        end
        if (c_rdy) begin
            left_q_reg  <= SUM_W'(lin_q_reg) - SUM_W'(yaw_q_reg);
            right_q_reg <= SUM_W'(lin_q_reg) + SUM_W'(yaw_q_reg);
        end
        if (d_rdy) begin
            pair_reg.left  <= round_clamp(left_q_reg, cfg.max_rpm);
            pair_reg.right <= round_clamp(right_q_reg, cfg.max_rpm);
        end
    end

    assign in_ready   = a_rdy;
    assign pair_valid = d_vld_reg;
    assign pair       = pair_reg;

endmodule

// ----- src/ddwcm_emit.sv -----
// Duplicate filter and command sequencer driving the result channel.
// Depends on ddwcm_pkg.
`timescale 1ns / 1ps

module ddwcm_emit #(
    parameter int GROUP_N = 3
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic [ddwcm_pkg::PWM_W-1:0]            pwm_limit,
    input  logic                                   pair_valid,
    output logic                                   pair_ready,
    input  ddwcm_pkg::pair_t                       pair,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic [ddwcm_pkg::MOTOR_W-1:0]          m_motor_id,
    output logic signed [ddwcm_pkg::RPM_W-1:0]     m_wheel_rpm,
    output logic [ddwcm_pkg::PWM_W-1:0]            m_limit_value,
    output logic                                   m_last
);
    import ddwcm_pkg::*;

    localparam logic [IDX_W-1:0] GRP      = IDX_W'(GROUP_N);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(2 * GROUP_N - 1);

    logic                    busy_reg, busy_next;
    logic [IDX_W-1:0]        idx_reg, idx_next;
    logic                    sent_reg, sent_next;
    logic signed [RPM_W-1:0] prev_left_reg, prev_right_reg;
    logic signed [RPM_W-1:0] left_reg, nright_reg;

    logic                    dup, finish, free, load, is_left;
    logic [IDX_W-1:0]        ridx;

    assign dup    = sent_reg && (pair.left == prev_left_reg) && (pair.right == prev_right_reg);
    assign finish = busy_reg && m_ready && (idx_reg == LAST_IDX);
    assign free   = !busy_reg || finish;
    assign load   = pair_valid && !dup && free;
    assign pair_ready = dup || free;

    always_comb begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        sent_next = sent_reg || load;
        if (load) begin
            busy_next = 1'b1;
            idx_next  = '0;
        end else if (finish) begin
            busy_next = 1'b0;
            idx_next  = '0;
        end else if (busy_reg && m_ready) begin
            idx_next  = idx_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
            sent_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
            sent_reg <= sent_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            left_reg       <= pair.left;
            nright_reg     <= -pair.right;
            prev_left_reg  <= pair.left;
            prev_right_reg <= pair.right;
        end
    end

    assign is_left = idx_reg < GRP;
    assign ridx    = idx_reg - GRP;

    assign m_valid       = busy_reg;
    assign m_motor_id    = is_left ? LEFT_IDS[idx_reg[1:0]] : RIGHT_IDS[ridx[1:0]];
    assign m_wheel_rpm   = is_left ? left_reg : nright_reg;
    assign m_limit_value = pwm_limit;
    assign m_last        = (idx_reg == LAST_IDX);

endmodule

// ----- src/diff_drive_wheel_command_mixer.sv -----
// Differential-drive wheel command mixer. A command passes the input, product, sum and round
// registers, then the sequencer. Input: one transfer per cycle unless the result port backs up;
// each changed pair takes the single result port for 2*GROUP_SIZE (within 2 to 6) transfers,
// which sets the sustained rate; an unchanged pair is dropped without using the result port.
// Reset (aresetn, synchronous, active low) empties the pipeline, clears the sent flag and
// restores the gain, clamp and pwm registers to their defaults.
`timescale 1ns / 1ps

module diff_drive_wheel_command_mixer #(
    parameter int GROUP_SIZE = 3
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    // configuration write port
    input  logic                                   cfg_wr_en,
    input  logic [ddwcm_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [ddwcm_pkg::CFG_W-1:0]            cfg_wdata,
    // command input
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic signed [ddwcm_pkg::LIN_W-1:0]     s_linear_speed,
    input  logic signed [ddwcm_pkg::TURN_W-1:0]    s_turn_rate,
    // motor command output
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic [ddwcm_pkg::MOTOR_W-1:0]          m_motor_id,
    output logic signed [ddwcm_pkg::RPM_W-1:0]     m_wheel_rpm,
    output logic [ddwcm_pkg::PWM_W-1:0]            m_limit_value,
    output logic                                   m_last
);
    import ddwcm_pkg::*;

    // Motors commanded per side: at least one, at most the three each side has
    localparam int GROUP_N = (GROUP_SIZE < 1) ? 1 :
                             (GROUP_SIZE > SIDE_MOTORS) ? SIDE_MOTORS : GROUP_SIZE;

    logic [GAIN_W-1:0]   lin_gain_reg, lin_gain_next;
    logic [GAIN_W-1:0]   yaw_gain_reg, yaw_gain_next;
    logic [RPMLIM_W-1:0] max_rpm_reg, max_rpm_next;
    logic [PWM_W-1:0]    pwm_limit_reg, pwm_limit_next;

    kin_cfg_t kin_cfg;
    logic     pair_valid, pair_ready;
    pair_t    pair;

    // Register file: take each write at once, truncated to the register width
    always_comb begin
        lin_gain_next  = lin_gain_reg;
        yaw_gain_next  = yaw_gain_reg;
        max_rpm_next   = max_rpm_reg;
        pwm_limit_next = pwm_limit_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                REG_LIN_GAIN:  lin_gain_next  = cfg_wdata[GAIN_W-1:0];
                REG_YAW_GAIN:  yaw_gain_next  = cfg_wdata[GAIN_W-1:0];
                REG_MAX_RPM:   max_rpm_next   = cfg_wdata[RPMLIM_W-1:0];
                REG_PWM_LIMIT: pwm_limit_next = cfg_wdata[PWM_W-1:0];
                default:       lin_gain_next  = lin_gain_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lin_gain_reg  <= LIN_GAIN_RST;
            yaw_gain_reg  <= YAW_GAIN_RST;
            max_rpm_reg   <= MAX_RPM_RST;
            pwm_limit_reg <= PWM_LIMIT_RST;
        end else begin
            lin_gain_reg  <= lin_gain_next;
            yaw_gain_reg  <= yaw_gain_next;
            max_rpm_reg   <= max_rpm_next;
            pwm_limit_reg <= pwm_limit_next;
        end
    end

    assign kin_cfg.lin_gain = lin_gain_reg;
    assign kin_cfg.yaw_gain = yaw_gain_reg;
    assign kin_cfg.max_rpm  = max_rpm_reg;

    // Four-stage arithmetic: hold inputs, form products, form sums, round and clamp
    ddwcm_kin u_kin (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg             (kin_cfg),
        .in_valid        (s_valid),
        .in_ready        (s_ready),
        .in_linear_speed (s_linear_speed),
        .in_turn_rate    (s_turn_rate),
        .pair_valid      (pair_valid),
        .pair_ready      (pair_ready),
        .pair            (pair)
    );

    // Drop a pair equal to the last one sent, otherwise step through the motor commands
    ddwcm_emit #(
        .GROUP_N (GROUP_N)
    ) u_emit (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .pwm_limit     (pwm_limit_reg),
        .pair_valid    (pair_valid),
        .pair_ready    (pair_ready),
        .pair          (pair),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_motor_id    (m_motor_id),
        .m_wheel_rpm   (m_wheel_rpm),
        .m_limit_value (m_limit_value),
        .m_last        (m_last)
    );

endmodule

// ----- dv/tb_top.sv -----
// Self-checking bench for the differential-drive wheel command mixer.
// Depends on src/ddwcm_pkg.sv and src/diff_drive_wheel_command_mixer.sv.
`timescale 1ns / 1ps

module tb_top;
    import ddwcm_pkg::*;

    localparam int GROUP_SIZE   = 3;
    localparam int DRAIN_CYCLES = 12;    // lets the pipeline empty of dropped pairs after the last command
    localparam int HOLD_CYCLES  = 400;   // long receiver hold-off
    localparam int STALL_LIMIT  = 3000;  // cycles with no transfer before giving up
    localparam int PHASE_QUOTA  = 41;    // commands offered per random phase
    localparam longint unsigned Q_ROUND = 64'd1 << (Q_SHIFT - 1);

    logic                        aclk;
    logic                        aresetn;
    logic                        cfg_wr_en;
    logic [CFG_IDX_W-1:0]        cfg_index;
    logic [CFG_W-1:0]            cfg_wdata;
    logic                        s_valid;
    logic                        s_ready;
    logic signed [LIN_W-1:0]     s_linear_speed;
    logic signed [TURN_W-1:0]    s_turn_rate;
    logic                        m_valid;
    logic                        m_ready;
    logic [MOTOR_W-1:0]          m_motor_id;
    logic signed [RPM_W-1:0]     m_wheel_rpm;
    logic [PWM_W-1:0]            m_limit_value;
    logic                        m_last;

    typedef struct {
        logic [MOTOR_W-1:0]      motor_id;
        logic signed [RPM_W-1:0] wheel_rpm;
        logic [PWM_W-1:0]        limit_value;
        logic                    last;
    } motor_cmd_t;

    // Mirror of the mixer: its registers, the last pair sent, and the motor
    // commands still owed on the result channel.
    class wheel_cmd_scoreboard;
        logic [GAIN_W-1:0]       lin_gain;
        logic [GAIN_W-1:0]       yaw_gain;
        logic [RPMLIM_W-1:0]     max_rpm;
        logic [PWM_W-1:0]        pwm_limit;
        bit                      pair_sent;
        logic signed [RPM_W-1:0] sent_left;
        logic signed [RPM_W-1:0] sent_right;
        motor_cmd_t              owed_cmds[$];
        int                      errors;

        function new();
            lin_gain   = LIN_GAIN_RST;
            yaw_gain   = YAW_GAIN_RST;
            max_rpm    = MAX_RPM_RST;
            pwm_limit  = PWM_LIMIT_RST;
            pair_sent  = 1'b0;
            sent_left  = '0;
            sent_right = '0;
            errors     = 0;
        endfunction

        function void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            case (idx)
                REG_LIN_GAIN:  lin_gain  = data[GAIN_W-1:0];
                REG_YAW_GAIN:  yaw_gain  = data[GAIN_W-1:0];
                REG_MAX_RPM:   max_rpm   = data[RPMLIM_W-1:0];
                REG_PWM_LIMIT: pwm_limit = data[PWM_W-1:0];
                default: ;
            endcase
        endfunction

        // Round a Q24 value half away from zero, then clamp to the rpm limit.
        function logic signed [RPM_W-1:0] rpm_from_q(longint q);
            longint unsigned         mag;
            longint unsigned         whole;
            logic signed [RPM_W-1:0] rpm;
            mag   = (q < 0) ? longint'(-q) : longint'(q);
            whole = (mag + Q_ROUND) >> Q_SHIFT;
            if (whole > longint'(max_rpm))
                whole = longint'(max_rpm);
            rpm = whole[RPM_W-1:0];
            return (q < 0) ? -rpm : rpm;
        endfunction

        function int side_count();
            int g;
            g = GROUP_SIZE;
            if (g < 1) g = 1;
            if (g > SIDE_MOTORS) g = SIDE_MOTORS;
            return g;
        endfunction

        // Note an accepted speed command; return how many motor commands it owes.
        function int note_command(logic signed [LIN_W-1:0] lin, logic signed [TURN_W-1:0] turn);
            longint                  lin_q;
            longint                  yaw_q;
            logic signed [RPM_W-1:0] left;
            logic signed [RPM_W-1:0] right;
            motor_cmd_t              cmd;
            int                      g;
            lin_q = longint'(lin) * longint'(lin_gain);
            yaw_q = longint'(turn) * longint'(yaw_gain);
            left  = rpm_from_q(lin_q - yaw_q);
            right = rpm_from_q(lin_q + yaw_q);
            g     = side_count();
            if (pair_sent && left == sent_left && right == sent_right)
                return 0;
            for (int k = 0; k < 2 * g; k++) begin
                cmd.motor_id    = (k < g) ? LEFT_IDS[k] : RIGHT_IDS[k - g];
                cmd.wheel_rpm   = (k < g) ? left : -right;
                cmd.limit_value = pwm_limit;
                cmd.last        = (k == 2 * g - 1);
                owed_cmds.push_back(cmd);
            end
            sent_left  = left;
            sent_right = right;
            pair_sent  = 1'b1;
            return 2 * g;
        endfunction

        function void check_motor_cmd(motor_cmd_t got);
            motor_cmd_t want;
            if (owed_cmds.size() == 0) begin
                $error("unexpected motor command: motor_id %0d wheel_rpm %0d",
                       got.motor_id, got.wheel_rpm);
                errors++;
                return;
            end
            want = owed_cmds.pop_front();
            if (got.motor_id !== want.motor_id) begin
                $error("motor_id: expected %0d, actual %0d", want.motor_id, got.motor_id);
                errors++;
            end
            if (got.wheel_rpm !== want.wheel_rpm) begin
                $error("wheel_rpm: expected %0d, actual %0d", want.wheel_rpm, got.wheel_rpm);
                errors++;
            end
            if (got.limit_value !== want.limit_value) begin
                $error("limit_value: expected %0d, actual %0d",
                       want.limit_value, got.limit_value);
                errors++;
            end
            if (got.last !== want.last) begin
                $error("last: expected %0d, actual %0d", want.last, got.last);
                errors++;
            end
        endfunction
    endclass

    wheel_cmd_scoreboard sb = new();

    // Hold-off requests from the stimulus side, served by the receiver.
    int hold_req = 0;

    // Last command offered, reused to provoke unchanged pairs.
    logic signed [LIN_W-1:0]  last_lin  = '0;
    logic signed [TURN_W-1:0] last_turn = '0;

    diff_drive_wheel_command_mixer #(
        .GROUP_SIZE(GROUP_SIZE)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_linear_speed(s_linear_speed),
        .s_turn_rate   (s_turn_rate),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_motor_id    (m_motor_id),
        .m_wheel_rpm   (m_wheel_rpm),
        .m_limit_value (m_limit_value),
        .m_last        (m_last)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Offer one command and hold it until the transfer; report what it owes.
    task automatic send_cmd(input logic signed [LIN_W-1:0] lin,
                            input logic signed [TURN_W-1:0] turn, output int owed);
        s_valid        <= 1'b1;
        s_linear_speed <= lin;
        s_turn_rate    <= turn;
        do @(posedge aclk); while (!s_ready);
        owed = sb.note_command(lin, turn);
    endtask

    // Drop valid and put junk on the payload, which the block must ignore.
    task automatic idle_sender();
        s_valid        <= 1'b0;
        s_linear_speed <= LIN_W'($urandom);
        s_turn_rate    <= TURN_W'($urandom);
    endtask

    // Wait for every owed command, then let the pipeline empty of dropped pairs.
    task automatic wait_drain();
        while (sb.owed_cmds.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Write all four registers, one per cycle, while the block is idle.
    task automatic set_config(input logic [CFG_W-1:0] lin_g, input logic [CFG_W-1:0] yaw_g,
                              input logic [CFG_W-1:0] rpm_lim, input logic [CFG_W-1:0] pwm_lim);
        logic [CFG_W-1:0]     vals [4];
        logic [CFG_IDX_W-1:0] regs [4];
        vals = '{lin_g, yaw_g, rpm_lim, pwm_lim};
        regs = '{REG_LIN_GAIN, REG_YAW_GAIN, REG_MAX_RPM, REG_PWM_LIMIT};
        for (int i = 0; i < 4; i++) begin
            cfg_wr_en <= 1'b1;
            cfg_index <= regs[i];
            cfg_wdata <= vals[i];
            @(posedge aclk);
            sb.apply_reg(regs[i], vals[i]);
        end
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [CFG_W-1:0] pick_gain();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return CFG_W'($urandom_range(0, 1 << 16));
            3, 4:    return CFG_W'($urandom_range(0, 1 << 21));
            default: return CFG_W'($urandom);
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] pick_rpm_limit();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return 24'd32767;
            2:       return CFG_W'($urandom_range(1, 20));
            3:       return CFG_W'($urandom);      // upper bits must be masked off
            default: return CFG_W'($urandom_range(0, 32767));
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] pick_pwm_limit();
        case ($urandom_range(0, 4))
            0:       return '0;
            1:       return 24'd5000;
            2:       return CFG_W'($urandom);      // above the normal range, masked to 13 bits
            default: return CFG_W'($urandom_range(0, 5000));
        endcase
    endfunction

    // Mostly well-formed commands, with repeats so that unchanged pairs occur.
    task automatic pick_command(output logic signed [LIN_W-1:0] lin,
                                output logic signed [TURN_W-1:0] turn);
        int mode;
        mode = $urandom_range(0, 99);
        if (mode < 18) begin
            lin  = last_lin;
            turn = last_turn;
        end else if (mode < 28) begin
            lin  = last_lin ^ LIN_W'($urandom_range(0, 3));
            turn = last_turn ^ TURN_W'($urandom_range(0, 3));
        end else if (mode < 48) begin
            lin  = LIN_W'(int'($urandom_range(0, 800)) - 400);
            turn = TURN_W'(int'($urandom_range(0, 200000)) - 100000);
        end else if (mode < 58) begin
            case ($urandom_range(0, 3))
                0: lin = 16'sh8000;
                1: lin = 16'sh7FFF;
                2: lin = '0;
                default: lin = '1;
            endcase
            case ($urandom_range(0, 3))
                0: turn = 24'sh800000;
                1: turn = 24'sh7FFFFF;
                2: turn = '0;
                default: turn = '1;
            endcase
        end else begin
            lin  = LIN_W'($urandom);
            turn = TURN_W'($urandom);
        end
        last_lin  = lin;
        last_turn = turn;
    endtask

    // Bursts of random length with random gaps; optionally pause half-way
    // until every owed command has been taken.
    task automatic run_random_phase(input bit pause_midway);
        logic signed [LIN_W-1:0]  lin;
        logic signed [TURN_W-1:0] turn;
        int owed;
        int tries;
        int burst_left;
        int gap;
        tries      = 0;
        burst_left = $urandom_range(1, 12);
        while (tries < PHASE_QUOTA) begin
            pick_command(lin, turn);
            send_cmd(lin, turn, owed);
            tries++;
            burst_left--;
            if (pause_midway && tries == PHASE_QUOTA / 2) begin
                idle_sender();
                wait_drain();
            end else if (burst_left == 0) begin
                burst_left = $urandom_range(1, 12);
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                if (gap != 0) begin
                    idle_sender();
                    repeat (gap) @(posedge aclk);
                end
            end
        end
        idle_sender();
    endtask

    // Receiver: check every transfer against the oldest owed command, then
    // choose ready from one of four patterns, picked anew at random.
    initial begin
        motor_cmd_t got;
        int mode;
        int mode_left;
        int hold_left;
        int hold_seen;
        int phase_cnt;
        mode      = 0;
        mode_left = 0;
        hold_left = 0;
        hold_seen = 0;
        phase_cnt = 0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn) begin
                if (m_valid && m_ready) begin
                    got.motor_id    = m_motor_id;
                    got.wheel_rpm   = m_wheel_rpm;
                    got.limit_value = m_limit_value;
                    got.last        = m_last;
                    sb.check_motor_cmd(got);
                end
                if (hold_req != hold_seen) begin
                    hold_seen = hold_req;
                    hold_left = HOLD_CYCLES;
                end
                if (mode_left == 0) begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(20, 60);
                end
                mode_left--;
                phase_cnt++;
                if (hold_left > 0) begin
                    hold_left--;
                    m_ready <= 1'b0;
                end else begin
                    case (mode)
                        0: m_ready <= 1'b1;                              // no stalls
                        1: m_ready <= ($urandom_range(0, 1) != 0);
                        2: m_ready <= ($urandom_range(0, 3) != 0);
                        default: m_ready <= (phase_cnt % 5 != 0);        // periodic bubble
                    endcase
                end
            end
        end
    end

    // Watchdog: give up when neither channel moves for too long.
    initial begin
        int idle_cnt;
        idle_cnt = 0;
        forever begin
            @(posedge aclk);
            if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
                idle_cnt = 0;
            else
                idle_cnt++;
            if (idle_cnt >= STALL_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // Stimulus: reset, directed commands over a few register settings, then
    // random phases with fresh settings between them.
    initial begin
        int owed;
        cfg_wr_en      <= 1'b0;
        cfg_index      <= '0;
        cfg_wdata      <= '0;
        s_valid        <= 1'b0;
        s_linear_speed <= '0;
        s_turn_rate    <= '0;
        aresetn        <= 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset settings: first pair is always sent, a repeat is dropped,
        // both inputs at their extremes stay inside the rpm limit, and a turn too small to move
        // the rounded rpm leaves the pair unchanged.
        send_cmd(16'sd0, 24'sd0, owed);
        send_cmd(16'sd0, 24'sd0, owed);
        send_cmd(16'sh7FFF, 24'sd0, owed);
        send_cmd(16'sh8000, 24'sd0, owed);
        send_cmd(16'sd0, 24'sh7FFFFF, owed);
        send_cmd(16'sd0, 24'sh800000, owed);
        send_cmd(16'sd100, 24'sd0, owed);
        send_cmd(16'sd100, 24'sd0, owed);
        send_cmd(16'sd100, 24'sd1, owed);
        send_cmd(16'sh7FFF, 24'sh7FFFFF, owed);
        send_cmd(16'sh8000, 24'sh800000, owed);
        idle_sender();
        wait_drain();

        // Half gain: odd speeds land exactly on a half and round away from zero.
        // Clamp and pwm writes have their upper bits masked.
        set_config(24'h800000, 24'h000000, 24'hFFFFFF, 24'hFFFFFF);
        send_cmd(16'sd1, 24'sd0, owed);
        send_cmd(-16'sd1, 24'sd0, owed);
        send_cmd(16'sd3, 24'sd0, owed);
        send_cmd(-16'sd3, 24'sd0, owed);
        send_cmd(16'sh7FFF, 24'sd123, owed);
        idle_sender();
        wait_drain();

        // Zero clamp: every rpm becomes zero, so only the first command is sent.
        set_config(24'hFFFFFF, 24'hFFFFFF, 24'h000000, 24'h000000);
        send_cmd(16'sd1234, -24'sd5678, owed);
        send_cmd(16'sh7FFF, 24'sh7FFFFF, owed);
        send_cmd(16'sh8000, 24'sh800000, owed);
        idle_sender();
        wait_drain();

        // Full gains with the widest clamp and the top of the pwm range.
        set_config(24'hFFFFFF, 24'hFFFFFF, 24'd32767, 24'd5000);
        send_cmd(16'sh8000, 24'sh7FFFFF, owed);
        send_cmd(16'sh7FFF, 24'sh800000, owed);
        send_cmd(16'sd1, -24'sd1, owed);
        idle_sender();
        wait_drain();

        for (int phase = 0; phase < 6; phase++) begin
            set_config(pick_gain(), pick_gain(), pick_rpm_limit(), pick_pwm_limit());
            // Hold the receiver off for a long stretch while commands keep coming.
            if (phase == 1)
                hold_req = hold_req + 1;
            run_random_phase(phase == 3);
            wait_drain();
        end

        if (sb.errors == 0 && sb.owed_cmds.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
